// ===== rtl/core/lr_pkg.sv =====
// Shared types, widths and helpers for the line rasterizer.
// Used by line_rasterizer; no other dependencies.
package lr_pkg;

  localparam int IN_W    = 8;   // endpoint field width
  localparam int COORD_W = 7;   // pixel coordinate width
  localparam int STEP_W  = 8;   // twice the minor distance
  localparam int ERR_W   = 10;  // signed error term and diagonal step
  localparam int OP_W    = 2;   // pixel operation code

  typedef enum logic {
    ACT_START = 1'b0,
    ACT_STEP  = 1'b1
  } action_t;

  typedef logic [COORD_W-1:0]      coord_t;
  typedef logic signed [ERR_W-1:0] err_t;

  // Clamp an endpoint field to the last screen coordinate.
  function automatic coord_t clamp_coord(logic [IN_W-1:0] v, logic [IN_W-1:0] lim_max);
    return (v > lim_max) ? lim_max[COORD_W-1:0] : v[COORD_W-1:0];
  endfunction

endpackage

// ===== rtl/core/line_rasterizer.sv =====
// Bresenham line stepper: one result per input transaction.
// Depends on lr_pkg for widths, the action code and the clamp helper.
//
//  channel | handshake                 | payload
//  --------+---------------------------+------------------------------------------
//  input   | in_valid, in_stall (out)  | action start_x start_y end_x end_y draw_mode
//  output  | out_valid, out_stall (in) | valid_res pixel_x pixel_y pixel_op last
//
// Line state and the result register load at the accepting edge, so a transaction
// can enter every clock while in_stall is low.
// The result appears in the cycle after acceptance and holds while out_stall is high.
// in_stall rises only when the result register is full and stalled.
// Synchronous reset clears all line state; no line is active after reset.
module line_rasterizer #(
  parameter int SCREEN_WIDTH  = 96,
  parameter int SCREEN_HEIGHT = 65
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic                      action,
  input  logic [lr_pkg::IN_W-1:0]   start_x,
  input  logic [lr_pkg::IN_W-1:0]   start_y,
  input  logic [lr_pkg::IN_W-1:0]   end_x,
  input  logic [lr_pkg::IN_W-1:0]   end_y,
  input  logic [lr_pkg::OP_W-1:0]   draw_mode,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic                      valid_res,
  output logic [lr_pkg::COORD_W-1:0] pixel_x,
  output logic [lr_pkg::COORD_W-1:0] pixel_y,
  output logic [lr_pkg::OP_W-1:0]   pixel_op,
  output logic                      last
);

  localparam logic [lr_pkg::IN_W-1:0] X_MAX = lr_pkg::IN_W'(SCREEN_WIDTH - 1);
  localparam logic [lr_pkg::IN_W-1:0] Y_MAX = lr_pkg::IN_W'(SCREEN_HEIGHT - 1);

  // line state
  lr_pkg::coord_t              cur_x, cur_x_next;
  lr_pkg::coord_t              cur_y, cur_y_next;
  lr_pkg::err_t                error_term, error_term_next;
  logic [lr_pkg::STEP_W-1:0]   minor_step, minor_step_next;
  lr_pkg::err_t                diag_step, diag_step_next;
  logic [lr_pkg::COORD_W-1:0]  pixels_left, pixels_left_next;
  logic                        x_major, x_major_next;
  logic                        x_backward, x_backward_next;
  logic                        y_backward, y_backward_next;
  logic                        active, active_next;
  logic [lr_pkg::OP_W-1:0]     line_op, line_op_next;

  // result
  logic                        valid_res_next;
  lr_pkg::coord_t              pixel_x_next, pixel_y_next;
  logic [lr_pkg::OP_W-1:0]     pixel_op_next;
  logic                        last_next;

  // start-item datapath
  lr_pkg::coord_t              x1, y1, x2, y2, dx, dy, major_d, minor_d;
  logic [lr_pkg::STEP_W-1:0]   minor2;
  lr_pkg::err_t                err_init;
  logic                        xb, yb, xm;

  // step datapath
  lr_pkg::coord_t              x_moved, y_moved;

  logic in_accept;

  assign in_stall  = out_valid && out_stall;
  assign in_accept = in_valid && !in_stall;

  always_comb begin
    x1 = lr_pkg::clamp_coord(start_x, X_MAX);
    y1 = lr_pkg::clamp_coord(start_y, Y_MAX);
    x2 = lr_pkg::clamp_coord(end_x, X_MAX);
    y2 = lr_pkg::clamp_coord(end_y, Y_MAX);
    xb = x1 > x2;
    yb = y1 > y2;
    dx = xb ? (x1 - x2) : (x2 - x1);
    dy = yb ? (y1 - y2) : (y2 - y1);
    xm = dx >= dy;
    major_d  = xm ? dx : dy;
    minor_d  = xm ? dy : dx;
    minor2   = {minor_d, 1'b0};
    err_init = $signed({2'b00, minor2}) - $signed({3'b000, major_d});
    x_moved  = x_backward ? (cur_x - 7'd1) : (cur_x + 7'd1);
    y_moved  = y_backward ? (cur_y - 7'd1) : (cur_y + 7'd1);
  end

  always_comb begin
    cur_x_next       = cur_x;
    cur_y_next       = cur_y;
    error_term_next  = error_term;
    minor_step_next  = minor_step;
    diag_step_next   = diag_step;
    pixels_left_next = pixels_left;
    x_major_next     = x_major;
    x_backward_next  = x_backward;
    y_backward_next  = y_backward;
    active_next      = active;
    line_op_next     = line_op;
    valid_res_next   = 1'b0;
    pixel_x_next     = '0;
    pixel_y_next     = '0;
    pixel_op_next    = '0;
    last_next        = 1'b0;

    if (lr_pkg::action_t'(action) == lr_pkg::ACT_START) begin
      cur_x_next       = x1;
      cur_y_next       = y1;
      x_backward_next  = xb;
      y_backward_next  = yb;
      x_major_next     = xm;
      minor_step_next  = minor2;
      error_term_next  = err_init;
      diag_step_next   = err_init - $signed({3'b000, major_d});
      pixels_left_next = major_d;
      line_op_next     = draw_mode;
      active_next      = (major_d != '0);
      valid_res_next   = 1'b1;
      pixel_x_next     = x1;
      pixel_y_next     = y1;
      pixel_op_next    = draw_mode;
      last_next        = (major_d == '0);
    end else if (active) begin
      if (error_term[lr_pkg::ERR_W-1]) begin
        // straight move along the major axis
        error_term_next = error_term + $signed({2'b00, minor_step});
        if (x_major) begin
          cur_x_next = x_moved;
        end else begin
          cur_y_next = y_moved;
        end
      end else begin
        error_term_next = error_term + diag_step;
        cur_x_next      = x_moved;
        cur_y_next      = y_moved;
      end
      pixels_left_next = pixels_left - 7'd1;
      active_next      = (pixels_left_next != '0);
      valid_res_next   = 1'b1;
      pixel_x_next     = cur_x_next;
      pixel_y_next     = cur_y_next;
      pixel_op_next    = line_op;
      last_next        = (pixels_left_next == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_x       <= '0;
      cur_y       <= '0;
      error_term  <= '0;
      minor_step  <= '0;
      diag_step   <= '0;
      pixels_left <= '0;
      x_major     <= 1'b0;
      x_backward  <= 1'b0;
      y_backward  <= 1'b0;
      active      <= 1'b0;
      line_op     <= '0;
    end else if (in_accept) begin
      cur_x       <= cur_x_next;
      cur_y       <= cur_y_next;
      error_term  <= error_term_next;
      minor_step  <= minor_step_next;
      diag_step   <= diag_step_next;
      pixels_left <= pixels_left_next;
      x_major     <= x_major_next;
      x_backward  <= x_backward_next;
      y_backward  <= y_backward_next;
      active      <= active_next;
      line_op     <= line_op_next;
    end
  end

  // result register: load on accept, drop once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_accept) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      valid_res <= valid_res_next;
      pixel_x   <= pixel_x_next;
      pixel_y   <= pixel_y_next;
      pixel_op  <= pixel_op_next;
      last      <= last_next;
    end
  end

  a_accept_loads_result: assert property (@(posedge clk) disable iff (rst)
    in_accept |=> out_valid)
    else $error("accepted transaction produced no result");

  a_idle_step_empty: assert property (@(posedge clk) disable iff (rst)
    (in_accept && action == lr_pkg::ACT_STEP && !active) |=> (out_valid && !valid_res))
    else $error("step with no active line emitted a pixel");

  a_empty_result_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !valid_res) |-> (pixel_x == '0 && pixel_y == '0 && pixel_op == '0 && !last))
    else $error("empty result carries nonzero fields");

  a_pixel_on_screen: assert property (@(posedge clk) disable iff (rst)
    (out_valid && valid_res) |->
      ({1'b0, pixel_x} <= X_MAX && {1'b0, pixel_y} <= Y_MAX))
    else $error("pixel outside the screen");

  a_last_ends_line: assert property (@(posedge clk) disable iff (rst)
    (in_accept && last_next) |=> !active)
    else $error("line still active after its last pixel");

endmodule
